// ----- rtl/lui_pkg.sv -----
// ----------------------------------------------------------------------------
// lui_pkg
// Shared types and constants for the Lehmer uniform integer generator.
// ----------------------------------------------------------------------------
package lui_pkg;

    // Generator constants (minimal standard Lehmer generator)
    localparam logic [30:0] LCG_MODULUS = 31'h7FFF_FFFF;
    localparam logic [14:0] LCG_MULT    = 15'd16807;

    // Command codes
    localparam logic CMD_DRAW = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    // Status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    // Classified item handed from the front end to the back end
    typedef struct packed {
        logic               cmd;        // draw or load
        logic signed [31:0] lo;         // ordered lower limit
        logic        [31:0] span_lo;    // span modulo 2^32
        logic               span_full;  // span is exactly 2^32
        logic        [30:0] seed_value; // seed for a load
    } item_t;

endpackage

// ----- rtl/lui_front.sv -----
// ----------------------------------------------------------------------------
// lui_front
// Front end: orders the two limits and works out the span of the range.
// ----------------------------------------------------------------------------
module lui_front
    import lui_pkg::*;
(
    input  logic               command,
    input  logic signed [31:0] low_limit,
    input  logic signed [31:0] high_limit,
    input  logic        [30:0] seed_value,
    output item_t              item
);

    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic        [31:0] diff;

    // Swap reversed limits
    always_comb
    begin
        if (high_limit < low_limit)
        begin
            lo = high_limit;
            hi = low_limit;
        end
        else
        begin
            lo = low_limit;
            hi = high_limit;
        end
    end

    // hi - lo fits 32 unsigned bits; span = diff + 1
    assign diff = 32'(hi) - 32'(lo);

    always_comb
    begin
        item.cmd        = command;
        item.lo         = lo;
        item.span_lo    = diff + 32'd1;
        item.span_full  = &diff;
        item.seed_value = seed_value;
    end

endmodule

// ----- rtl/lui_queue.sv -----
// ----------------------------------------------------------------------------
// lui_queue
// Two-entry queue of classified items between the front and back ends.
// ----------------------------------------------------------------------------
module lui_queue
    import lui_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output item_t head_item
);

    item_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_item  = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and fill count
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- rtl/lui_back.sv -----
// ----------------------------------------------------------------------------
// lui_back
// Back end: holds the generator seed, advances it, scales the draw onto the
// range and drives the registered result.
// ----------------------------------------------------------------------------
module lui_back
    import lui_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  item_t              head_item,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] sample,
    output logic        [30:0] next_seed,
    output logic               status
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LCG  = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [30:0]        seed_reg;
    logic [30:0]        seed_next;
    logic               status_reg;
    logic               status_next;
    logic               draw_reg;
    logic               draw_next;
    logic signed [31:0] lo_reg;
    logic [31:0]        span_reg;
    logic               full_reg;
    logic [62:0]        prod_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic signed [31:0] sample_reg;
    logic [30:0]        next_seed_reg;
    logic               out_status_reg;
    logic               out_free;
    logic               seed_bad;
    logic [30:0]        lcg_seed;
    logic [31:0]        offset;

    // One generator step: multiply by 16807, fold twice mod 2^31-1
    function automatic logic [30:0] lcg_step(input logic [30:0] s);
        logic [45:0] p;
        logic [31:0] r;
        logic [31:0] r2;
        p  = 46'(s) * 46'(LCG_MULT);
        r  = {1'b0, p[30:0]} + {17'd0, p[45:31]};
        r2 = {1'b0, r[30:0]} + {31'd0, r[31]};
        if (r2 >= {1'b0, LCG_MODULUS})
        begin
            r2 = r2 - {1'b0, LCG_MODULUS};
        end
        return r2[30:0];
    endfunction

    assign lcg_seed = lcg_step(seed_reg);
    assign out_free = !out_valid_reg || out_ready;
    assign seed_bad = (head_item.seed_value == 31'd0) ||
                      (head_item.seed_value == LCG_MODULUS);
    assign pop      = (state_reg == ST_IDLE) && head_valid;

    // Offset into the range; a full span is a plain shift
    assign offset = full_reg ? {seed_reg, 1'b0} : prod_reg[62:31];

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        seed_next      = seed_reg;
        status_next    = status_reg;
        draw_next      = draw_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    if (head_item.cmd == CMD_LOAD)
                    begin
                        draw_next  = 1'b0;
                        state_next = ST_FIN;
                        if (seed_bad)
                        begin
                            status_next = STATUS_BAD;
                        end
                        else
                        begin
                            status_next = STATUS_OK;
                            seed_next   = head_item.seed_value;
                        end
                    end
                    else
                    begin
                        draw_next   = 1'b1;
                        status_next = STATUS_OK;
                        state_next  = ST_LCG;
                    end
                end
            end
            ST_LCG:
            begin
                seed_next  = lcg_seed;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seed_reg      <= 31'd1;
            status_reg    <= STATUS_OK;
            draw_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seed_reg      <= seed_next;
            status_reg    <= status_next;
            draw_reg      <= draw_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Item operands, scaling product and result payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            lo_reg   <= head_item.lo;
            span_reg <= head_item.span_lo;
            full_reg <= head_item.span_full;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= 63'(seed_reg) * 63'(span_reg);
        end
        if ((state_reg == ST_FIN) && out_free)
        begin
            sample_reg     <= draw_reg ? (lo_reg + $signed(offset)) : 32'sd0;
            next_seed_reg  <= seed_reg;
            out_status_reg <= status_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;
    assign next_seed = next_seed_reg;
    assign status    = out_status_reg;

endmodule

// ----- rtl/lehmer_uniform_int_in_range.sv -----
// ----------------------------------------------------------------------------
// lehmer_uniform_int_in_range
// Uniform integer draw in [low, high] from a 31-bit Lehmer generator, with a
// seed load command.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_ready  | command, low_limit, high_limit, seed_value
//  out     | out_valid / out_ready| sample, next_seed, status
//
//  A draw passes through the back-end states dequeue, generator step, scaling
//  multiply and result; a load passes through dequeue and result. The back end
//  handles one item at a time. A two-entry queue takes up to two beats while
//  the back end works or the result waits; in_ready drops once both entries
//  are taken. Reset sets the seed to 1; no clearing pass.
// ----------------------------------------------------------------------------
module lehmer_uniform_int_in_range
    import lui_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               command,
    input  logic signed [31:0] low_limit,
    input  logic signed [31:0] high_limit,
    input  logic        [30:0] seed_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] sample,
    output logic        [30:0] next_seed,
    output logic               status
);

    item_t front_item;
    item_t head_item;
    logic  q_full;
    logic  head_valid;
    logic  pop;

    lui_front u_front
    (
        .command    (command),
        .low_limit  (low_limit),
        .high_limit (high_limit),
        .seed_value (seed_value),
        .item       (front_item)
    );

    lui_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_valid),
        .push_item  (front_item),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    assign in_ready = !q_full;

    lui_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample     (sample),
        .next_seed  (next_seed),
        .status     (status)
    );

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Lehmer uniform integer generator. Directed and
// random draws and seed loads go in through the input channel. A predictor
// inside the bench tracks the generator seed and works out each expected
// sample, seed and status. Every result beat is checked against the oldest
// expectation while both sides idle and stall at random in several phases.
// ----------------------------------------------------------------------------
module tb
    import lui_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int RANDOM_ITEMS   = 320;   // per idling phase, four phases

    typedef struct {
        logic signed [31:0] sample;
        logic        [30:0] seed;
        logic               status;
    } draw_result_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               command;
    logic signed [31:0] low_limit;
    logic signed [31:0] high_limit;
    logic        [30:0] seed_value;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] sample;
    logic        [30:0] next_seed;
    logic               status;

    // Predictor state and scoreboard
    logic [30:0]  gen_seed_model;
    draw_result_t pending_results[$];

    int error_count;
    int draws_sent;
    int loads_sent;
    int loads_refused;
    int results_checked;
    int idle_cycles;
    int sender_idle_pct;
    int recv_stall_pct;

    lehmer_uniform_int_in_range DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .low_limit  (low_limit),
        .high_limit (high_limit),
        .seed_value (seed_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample     (sample),
        .next_seed  (next_seed),
        .status     (status)
    );

    // 12 ns clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // One Lehmer step: seed * multiplier mod (2^31 - 1)
    function automatic logic [30:0] lehmer_advance(input logic [30:0] seed);
        longint prod;
        begin
            prod = longint'(seed) * longint'(LCG_MULT);
            return 31'(prod % longint'(LCG_MODULUS));
        end
    endfunction

    // Expected result of one item; updates the tracked seed
    function automatic draw_result_t predict_draw(input logic cmd,
                                                  input logic signed [31:0] lim_a,
                                                  input logic signed [31:0] lim_b,
                                                  input logic [30:0] load_val);
        draw_result_t res;
        longint lo;
        longint hi;
        longint span;
        longint offset;
        longint value;
        begin
            res.sample = '0;
            res.status = STATUS_OK;
            if (cmd == CMD_LOAD)
            begin
                if (load_val == '0 || load_val == LCG_MODULUS)
                    res.status = STATUS_BAD;
                else
                    gen_seed_model = load_val;
            end
            else
            begin
                lo = lim_a;
                hi = lim_b;
                if (hi < lo)
                begin
                    lo = lim_b;
                    hi = lim_a;
                end
                span = hi - lo + 1;
                gen_seed_model = lehmer_advance(gen_seed_model);
                offset = (longint'(gen_seed_model) * span) >>> 31;
                value = lo + offset;
                if (value < lo)
                    value = lo;
                if (value > hi)
                    value = hi;
                res.sample = 32'(value);
            end
            res.seed = gen_seed_model;
            return res;
        end
    endfunction

    // Sends one beat; entered and left at a falling edge
    task automatic send_item(input logic cmd, input logic signed [31:0] lim_a,
                             input logic signed [31:0] lim_b, input logic [30:0] load_val);
        draw_result_t res;
        begin
            // random gaps, payload scrambled while valid is low
            while ($urandom_range(99) < sender_idle_pct)
            begin
                in_valid   <= 1'b0;
                command    <= 1'($urandom);
                low_limit  <= $urandom;
                high_limit <= $urandom;
                seed_value <= 31'($urandom);
                @(negedge clk);
            end
            in_valid   <= 1'b1;
            command    <= cmd;
            low_limit  <= lim_a;
            high_limit <= lim_b;
            seed_value <= load_val;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            res = predict_draw(cmd, lim_a, lim_b, load_val);
            pending_results.push_back(res);
            if (cmd == CMD_LOAD)
            begin
                loads_sent++;
                if (res.status == STATUS_BAD)
                    loads_refused++;
            end
            else
                draws_sent++;
            @(negedge clk);
        end
    endtask

    // Receiver back-pressure
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Result checker
    always @(posedge clk)
    begin
        draw_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result beat sample=%0d seed=%0d status=%0d",
                         $time, sample, next_seed, status);
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (sample !== want.sample)
                begin
                    error_count++;
                    $display("%0t: sample mismatch expected %0d actual %0d",
                             $time, want.sample, sample);
                end
                if (next_seed !== want.seed)
                begin
                    error_count++;
                    $display("%0t: next_seed mismatch expected %0d actual %0d",
                             $time, want.seed, next_seed);
                end
                if (status !== want.status)
                begin
                    error_count++;
                    $display("%0t: status mismatch expected %0d actual %0d",
                             $time, want.status, status);
                end
            end
        end
    end

    // Watchdog: cycles with no beat on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d results outstanding",
                     $time, pending_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Limit extremes and ordering, starting from the reset seed
    task automatic test_range_edges();
        begin
            send_item(CMD_DRAW, 32'sh8000_0000, 32'sh7FFF_FFFF, '0);
            send_item(CMD_DRAW, 32'sh7FFF_FFFF, 32'sh8000_0000, '0);
            send_item(CMD_DRAW, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, '0);
            send_item(CMD_DRAW, 32'sh8000_0000, 32'sh8000_0000, '0);
            send_item(CMD_DRAW, 32'sh0, 32'sh0, '0);
            send_item(CMD_DRAW, -32'sd1, 32'sh0, '0);
            send_item(CMD_DRAW, 32'sd5, -32'sd5, '0);
            send_item(CMD_DRAW, 32'sh0, 32'sh1, '0);
            send_item(CMD_DRAW, 32'sh0, 32'sh7FFF_FFFF, '0);
            // seed field is ignored on a draw
            send_item(CMD_DRAW, 32'sh8000_0000, -32'sd1, 31'h7FFF_FFFF);
        end
    endtask

    // Seed loads, including the refused values
    task automatic test_seed_loads();
        begin
            // limits are ignored on a load
            send_item(CMD_LOAD, 32'sh7FFF_FFFF, 32'sh8000_0000, '0);
            send_item(CMD_LOAD, -32'sd1, -32'sd1, 31'h7FFF_FFFF);
            send_item(CMD_DRAW, 32'sh8000_0000, 32'sh7FFF_FFFF, '0);
            send_item(CMD_LOAD, '0, '0, 31'd1);
            send_item(CMD_DRAW, 32'sd0, 32'sd99, '0);
            send_item(CMD_LOAD, '0, '0, 31'h7FFF_FFFE);
            send_item(CMD_DRAW, 32'sh8000_0000, 32'sh7FFF_FFFF, '0);
            send_item(CMD_DRAW, 32'sh7FFF_FFFF, 32'sh0, '0);
            send_item(CMD_LOAD, '0, '0, 31'h5555_5555);
            send_item(CMD_LOAD, '0, '0, 31'h2AAA_AAAA);
            send_item(CMD_DRAW, -32'sd1000, 32'sd1000, '0);
        end
    endtask

    // Mixed random traffic under one idling pattern
    task automatic test_random_traffic(input int snd_pct, input int rcv_pct, input int count);
        logic               cmd;
        logic signed [31:0] lim_a;
        logic signed [31:0] lim_b;
        logic        [30:0] load_val;
        begin
            sender_idle_pct = snd_pct;
            recv_stall_pct  = rcv_pct;
            repeat (count)
            begin
                cmd      = ($urandom_range(5) == 0) ? CMD_LOAD : CMD_DRAW;
                lim_a    = $urandom;
                lim_b    = $urandom;
                load_val = 31'($urandom);
                if (cmd == CMD_LOAD)
                begin
                    case ($urandom_range(9))
                        0: load_val = '0;
                        1: load_val = 31'h7FFF_FFFF;
                        2: load_val = 31'h7FFF_FFFE;
                        3: load_val = 31'd1;
                        default: load_val = 31'($urandom_range(32'h7FFF_FFFE, 1));
                    endcase
                end
                else
                begin
                    case ($urandom_range(7))
                        1: lim_b = lim_a + $urandom_range(15);
                        2: lim_b = lim_a;
                        3:
                        begin
                            lim_a = 32'sh8000_0000;
                            lim_b = 32'sh7FFF_FFFF;
                            if ($urandom_range(1))
                            begin
                                lim_a = 32'sh7FFF_FFFF;
                                lim_b = 32'sh8000_0000;
                            end
                        end
                        4:
                        begin
                            lim_a = $signed($urandom_range(100)) - 50;
                            lim_b = $signed($urandom_range(100)) - 50;
                        end
                        5:
                        begin
                            lim_a = 32'sh8000_0000 + $urandom_range(255);
                            lim_b = 32'sh7FFF_FFFF - $urandom_range(255);
                        end
                        6: lim_b = lim_a - $urandom_range(1000);
                        default: ;
                    endcase
                end
                send_item(cmd, lim_a, lim_b, load_val);
            end
        end
    endtask

    // Main sequence
    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        command         = CMD_DRAW;
        low_limit       = '0;
        high_limit      = '0;
        seed_value      = '0;
        out_ready       = 1'b0;
        gen_seed_model  = 31'd1;
        error_count     = 0;
        draws_sent      = 0;
        loads_sent      = 0;
        loads_refused   = 0;
        results_checked = 0;
        idle_cycles     = 0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_range_edges();
        test_seed_loads();
        test_random_traffic(0, 0, RANDOM_ITEMS);
        test_random_traffic(85, 0, RANDOM_ITEMS);
        test_random_traffic(0, 85, RANDOM_ITEMS);
        test_random_traffic(16, 16, RANDOM_ITEMS);

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            error_count++;
            $display("%0t: %0d expected results never arrived", $time,
                     pending_results.size());
        end

        $display("Covered %0d draws and %0d seed loads (%0d refused), %0d results checked,",
                 draws_sent, loads_sent, loads_refused, results_checked);
        $display("under no idling, sender gaps, receiver stalls and both; %0d errors",
                 error_count);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/lui_pkg.sv
rtl/lui_front.sv
rtl/lui_queue.sv
rtl/lui_back.sv
rtl/lehmer_uniform_int_in_range.sv
verif/tb.sv
